// ----- rtl/rmq_pkg.sv -----
`default_nettype none
package rmq_pkg;

    localparam int FRACTION_BITS = 30;
    localparam int INT_FRAC      = 30;
    localparam int QSH           = INT_FRAC - FRACTION_BITS;
    localparam int CW            = 36 + QSH;
    localparam int STAGES        = 30;
    localparam int SQ_STEPS      = 32;
    localparam int SW            = 64;
    localparam int NST           = 1 + SQ_STEPS + 2 * STAGES + 3;

    localparam logic signed [CW-1:0] PI_Q     = CW'(64'sd3373259426);
    localparam logic signed [CW-1:0] ONE_Q    = CW'(64'sd1073741824);
    localparam logic signed [CW-1:0] GAIN_INV = CW'(64'sd652032874);
    localparam logic signed [32:0]   ONE_33   = 33'sd1073741824;
    localparam logic signed [32:0]   RND_OUT  = 33'sd1 <<< QSH >>> 1;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
    } vec_t;

    typedef struct packed {
        logic [SW-1:0] v;
        logic [SW-1:0] res;
    } sq_t;

    function automatic logic [CW-1:0] atan_step(input logic [4:0] i);
        logic [29:0] t;
        unique case (i)
            5'd0:    t = 30'd843314857;
            5'd1:    t = 30'd497837829;
            5'd2:    t = 30'd263043837;
            5'd3:    t = 30'd133525159;
            5'd4:    t = 30'd67021687;
            5'd5:    t = 30'd33543516;
            5'd6:    t = 30'd16775851;
            5'd7:    t = 30'd8388437;
            5'd8:    t = 30'd4194283;
            5'd9:    t = 30'd2097149;
            default: t = 30'd1 << (5'd30 - i);
        endcase
        return {{(CW-30){1'b0}}, t};
    endfunction

    function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sd536870912;
        return p[61:30];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/rmq_sqrt_cell.sv -----
`default_nettype none
module rmq_sqrt_cell
    import rmq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       en,
    input  wire logic [4:0] idx,
    input  wire sq_t        d,
    output sq_t             q
);

    sq_t           q_reg;
    sq_t           q_next;
    logic [SW-1:0] b;
    logic [SW-1:0] t;

    always_comb
    begin
        b = SW'(1) << (6'd62 - {idx, 1'b0});
        t = d.res + b;
        if (d.v >= t)
        begin
            q_next.v   = d.v - t;
            q_next.res = (d.res >> 1) + b;
        end
        else
        begin
            q_next.v   = d.v;
            q_next.res = d.res >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule
`default_nettype wire

// ----- rtl/rmq_vec_cell.sv -----
`default_nettype none
module rmq_vec_cell
    import rmq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       en,
    input  wire logic [4:0] idx,
    input  wire vec_t       d,
    output vec_t            q
);

    vec_t                 q_reg;
    vec_t                 q_next;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    always_comb
    begin
        x      = $signed(d.x);
        y      = $signed(d.y);
        dx     = x >>> idx;
        dy     = y >>> idx;
        q_next = d;
        if (y > 0)
        begin
            q_next.x = x + dy;
            q_next.y = y - dx;
            q_next.z = d.z + atan_step(idx);
        end
        else if (y < 0)
        begin
            q_next.x = x - dy;
            q_next.y = y + dx;
            q_next.z = d.z - atan_step(idx);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule
`default_nettype wire

// ----- rtl/rmq_rot_cell.sv -----
`default_nettype none
module rmq_rot_cell
    import rmq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       en,
    input  wire logic [4:0] idx,
    input  wire vec_t       d,
    output vec_t            q
);

    vec_t                 q_reg;
    vec_t                 q_next;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    always_comb
    begin
        dx = $signed(d.x) >>> idx;
        dy = $signed(d.y) >>> idx;
        if (!d.z[CW-1])
        begin
            q_next.x = d.x - dy;
            q_next.y = d.y + dx;
            q_next.z = d.z - atan_step(idx);
        end
        else
        begin
            q_next.x = d.x + dy;
            q_next.y = d.y - dx;
            q_next.z = d.z + atan_step(idx);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule
`default_nettype wire

// ----- rtl/rmq_quat.sv -----
`default_nettype none
module rmq_quat
    import rmq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [31:0] cr,
    input  wire logic signed [31:0] sr,
    input  wire logic signed [31:0] cp,
    input  wire logic signed [31:0] sp,
    input  wire logic signed [31:0] cy,
    input  wire logic signed [31:0] sy,
    output logic signed [31:0]      qw,
    output logic signed [31:0]      qx,
    output logic signed [31:0]      qy,
    output logic signed [31:0]      qz
);

    logic signed [31:0] crcp_reg;
    logic signed [31:0] srsp_reg;
    logic signed [31:0] srcp_reg;
    logic signed [31:0] crsp_reg;
    logic signed [31:0] cy_reg;
    logic signed [31:0] sy_reg;
    logic signed [31:0] p_reg [8];
    logic signed [31:0] qw_reg;
    logic signed [31:0] qx_reg;
    logic signed [31:0] qy_reg;
    logic signed [31:0] qz_reg;

    function automatic logic signed [31:0] fin(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               input logic               sub);
        logic signed [32:0] s;
        logic signed [32:0] r;
        s = sub ? (33'(a) - 33'(b)) : (33'(a) + 33'(b));
        if (s > ONE_33)
        begin
            s = ONE_33;
        end
        if (s < -ONE_33)
        begin
            s = -ONE_33;
        end
        r = (s + RND_OUT) >>> QSH;
        return r[31:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            crcp_reg <= mulq(cr, cp);
            srsp_reg <= mulq(sr, sp);
            srcp_reg <= mulq(sr, cp);
            crsp_reg <= mulq(cr, sp);
            cy_reg   <= cy;
            sy_reg   <= sy;
            p_reg[0] <= mulq(crcp_reg, cy_reg);
            p_reg[1] <= mulq(srsp_reg, sy_reg);
            p_reg[2] <= mulq(srcp_reg, cy_reg);
            p_reg[3] <= mulq(crsp_reg, sy_reg);
            p_reg[4] <= mulq(crsp_reg, cy_reg);
            p_reg[5] <= mulq(srcp_reg, sy_reg);
            p_reg[6] <= mulq(crcp_reg, sy_reg);
            p_reg[7] <= mulq(srsp_reg, cy_reg);
            qw_reg   <= fin(p_reg[0], p_reg[1], 1'b0);
            qx_reg   <= fin(p_reg[2], p_reg[3], 1'b1);
            qy_reg   <= fin(p_reg[4], p_reg[5], 1'b0);
            qz_reg   <= fin(p_reg[6], p_reg[7], 1'b1);
        end
    end

    assign qw = qw_reg;
    assign qx = qx_reg;
    assign qy = qy_reg;
    assign qz = qz_reg;

endmodule
`default_nettype wire

// ----- rtl/rotation_matrix_to_quaternion_unit.sv -----
// Channel   Dir  Fields (low bit up)
// s_axis    in   rot_00 rot_10 rot_20 rot_21 rot_22 trans_x trans_y trans_z
// m_axis    out  pos_x pos_y pos_z quat_w quat_x quat_y quat_z
//
// One word per cycle while the pipe is not stalled; stages: input register, 32 square root
// cells, 30 vectoring cells, 30 rotation cells, 3 multiply stages.
// Reset clears the valid bits of every stage.
// A held output word stalls the whole pipe; s_axis_tready then follows
// m_axis_tready.
`default_nettype none
module rotation_matrix_to_quaternion_unit
    import rmq_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // rot_00, rot_10, rot_20, rot_21, rot_22, trans_x, trans_y, trans_z
    input  wire logic [255:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z
    output logic [223:0]      m_axis_tdata
);

    logic                 adv;
    logic                 valid_reg [NST];
    logic [95:0]          trans_reg [NST];
    sq_t                  sq [SQ_STEPS+1];
    sq_t                  sq0_reg;
    logic signed [31:0]   a_reg    [SQ_STEPS+1];
    vec_t                 roll_reg [SQ_STEPS+1];
    vec_t                 yaw_reg  [SQ_STEPS+1];
    vec_t                 vv [3][STAGES+1];
    vec_t                 rr [3][STAGES+1];
    logic signed [CW-1:0] r00;
    logic signed [CW-1:0] r10;
    logic signed [CW-1:0] r20;
    logic signed [CW-1:0] r21;
    logic signed [CW-1:0] r22;
    logic signed [CW-1:0] na;
    logic signed [CW-1:0] ca;
    logic signed [31:0]   a32;
    logic signed [63:0]   aa;
    logic signed [31:0]   qw;
    logic signed [31:0]   qx;
    logic signed [31:0]   qy;
    logic signed [31:0]   qz;

    function automatic vec_t fold(input logic signed [CW-1:0] y,
                                  input logic signed [CW-1:0] x);
        vec_t f;
        f.x = x;
        f.y = y;
        f.z = '0;
        if (x < 0)
        begin
            f.x = -x;
            f.y = -y;
            f.z = (y >= 0) ? PI_Q : -PI_Q;
        end
        return f;
    endfunction

    assign adv           = !valid_reg[NST-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = valid_reg[NST-1];
    assign m_axis_tdata  = {qz, qy, qx, qw, trans_reg[NST-1]};

    always_comb
    begin
        r00 = CW'($signed(s_axis_tdata[31:0]))    <<< QSH;
        r10 = CW'($signed(s_axis_tdata[63:32]))   <<< QSH;
        r20 = CW'($signed(s_axis_tdata[95:64]))   <<< QSH;
        r21 = CW'($signed(s_axis_tdata[127:96]))  <<< QSH;
        r22 = CW'($signed(s_axis_tdata[159:128])) <<< QSH;
        na  = -r20;
        ca  = (na > ONE_Q) ? ONE_Q : ((na < -ONE_Q) ? -ONE_Q : na);
        a32 = ca[31:0];
        aa  = 64'(a32) * 64'(a32);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= s_axis_tvalid;
            for (int k = 1; k < NST; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            trans_reg[0] <= s_axis_tdata[255:160];
            for (int k = 1; k < NST; k++)
            begin
                trans_reg[k] <= trans_reg[k-1];
            end
            sq0_reg.v   <= (SW'(1) << 60) - SW'(aa);
            sq0_reg.res <= '0;
            a_reg[0]    <= a32;
            roll_reg[0] <= fold(r21, r22);
            yaw_reg[0]  <= fold(r10, r00);
            for (int k = 1; k <= SQ_STEPS; k++)
            begin
                a_reg[k]    <= a_reg[k-1];
                roll_reg[k] <= roll_reg[k-1];
                yaw_reg[k]  <= yaw_reg[k-1];
            end
        end
    end

    assign sq[0] = sq0_reg;

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        rmq_sqrt_cell u_cell (
            .clk (clk),
            .en  (adv),
            .idx (5'(k)),
            .d   (sq[k]),
            .q   (sq[k+1])
        );
    end

    assign vv[0][0]   = roll_reg[SQ_STEPS];
    assign vv[1][0].x = sq[SQ_STEPS].res[CW-1:0];
    assign vv[1][0].y = CW'(a_reg[SQ_STEPS]);
    assign vv[1][0].z = '0;
    assign vv[2][0]   = yaw_reg[SQ_STEPS];

    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        assign rr[l][0].x = GAIN_INV;
        assign rr[l][0].y = '0;
        assign rr[l][0].z = $signed(vv[l][STAGES].z) >>> 1;

        for (genvar k = 0; k < STAGES; k++)
        begin : g_stage
            rmq_vec_cell u_vec (
                .clk (clk),
                .en  (adv),
                .idx (5'(k)),
                .d   (vv[l][k]),
                .q   (vv[l][k+1])
            );

            rmq_rot_cell u_rot (
                .clk (clk),
                .en  (adv),
                .idx (5'(k)),
                .d   (rr[l][k]),
                .q   (rr[l][k+1])
            );
        end
    end

    rmq_quat u_quat (
        .clk (clk),
        .en  (adv),
        .cr  (rr[0][STAGES].x[31:0]),
        .sr  (rr[0][STAGES].y[31:0]),
        .cp  (rr[1][STAGES].x[31:0]),
        .sp  (rr[1][STAGES].y[31:0]),
        .cy  (rr[2][STAGES].x[31:0]),
        .sy  (rr[2][STAGES].y[31:0]),
        .qw  (qw),
        .qx  (qx),
        .qy  (qy),
        .qz  (qz)
    );

endmodule
`default_nettype wire

// ----- bench/rotation_matrix_to_quaternion_unit_tb.sv -----
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_unit_tb;
    import rmq_pkg::*;

    localparam longint ONE    = 64'sd1073741824;
    localparam longint PI_FX  = 64'sd3373259426;
    localparam longint GAIN_F = 64'sd652032874;
    localparam int     LIMIT  = 200000;
    localparam int     TAIL   = 60;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [223:0] m_axis_tdata;

    logic [255:0] pending_poses[$];
    logic [223:0] expected_poses[$];
    int           errors;
    int           cycles;
    int           send_gap;
    int           sink_stall;

    rotation_matrix_to_quaternion_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic longint sx32(input logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint arc_step(input int i);
        longint head[10];
        head = '{843314857, 497837829, 263043837, 133525159, 67021687,
                 33543516, 16775851, 8388437, 4194283, 2097149};
        if (i < 10)
            return head[i];
        return 64'sd1 << (30 - i);
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic longint vector_angle(input longint yi, input longint xi);
        longint x, y, z, dx, dy;
        x = xi;
        y = yi;
        z = 0;
        if (x < 0)
        begin
            z = (y >= 0) ? PI_FX : -PI_FX;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 30; i++)
        begin
            dx = x >>> i;
            dy = y >>> i;
            if (y > 0)
            begin
                x += dy; y -= dx; z += arc_step(i);
            end
            else if (y < 0)
            begin
                x -= dy; y += dx; z -= arc_step(i);
            end
        end
        return z;
    endfunction

    function automatic void rotate_unit(input longint zi, output longint c,
                                        output longint s);
        longint x, y, z, dx, dy;
        x = GAIN_F;
        y = 0;
        z = zi;
        for (int i = 0; i < 30; i++)
        begin
            dx = x >>> i;
            dy = y >>> i;
            if (z >= 0)
            begin
                x -= dy; y += dx; z -= arc_step(i);
            end
            else
            begin
                x += dy; y -= dx; z += arc_step(i);
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic longint int_root(input longint unsigned vi);
        longint unsigned v, res, b;
        v = vi;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic logic [31:0] clamp_unit(input longint q);
        if (q > ONE)
            q = ONE;
        if (q < -ONE)
            q = -ONE;
        return q[31:0];
    endfunction

    function automatic logic [223:0] pose_quaternion(input logic [255:0] d);
        longint r00, r10, r20, r21, r22, a, root, roll, pitch, yaw;
        longint cr, sr, cp, sp, cy, sy, crcp, srsp, srcp, crsp;
        logic [223:0] o;
        r00 = sx32(d[31:0]);
        r10 = sx32(d[63:32]);
        r20 = sx32(d[95:64]);
        r21 = sx32(d[127:96]);
        r22 = sx32(d[159:128]);
        a = -r20;
        if (a > ONE)
            a = ONE;
        if (a < -ONE)
            a = -ONE;
        root = int_root(ONE * ONE - a * a);
        roll = vector_angle(r21, r22);
        pitch = vector_angle(a, root);
        yaw = vector_angle(r10, r00);
        rotate_unit(roll >>> 1, cr, sr);
        rotate_unit(pitch >>> 1, cp, sp);
        rotate_unit(yaw >>> 1, cy, sy);
        crcp = fx_mul(cr, cp);
        srsp = fx_mul(sr, sp);
        srcp = fx_mul(sr, cp);
        crsp = fx_mul(cr, sp);
        o[95:0]    = d[255:160];
        o[127:96]  = clamp_unit(fx_mul(crcp, cy) + fx_mul(srsp, sy));
        o[159:128] = clamp_unit(fx_mul(srcp, cy) - fx_mul(crsp, sy));
        o[191:160] = clamp_unit(fx_mul(crsp, cy) + fx_mul(srcp, sy));
        o[223:192] = clamp_unit(fx_mul(crcp, sy) - fx_mul(srsp, cy));
        return o;
    endfunction

    function automatic logic [31:0] rand_entry();
        return 32'(int'($urandom_range(0, 2 * 1073741824)) - 1073741824);
    endfunction

    function automatic logic [31:0] to_fx(input real v);
        longint q;
        q = longint'(v * 1073741824.0);
        if (q > ONE)
            q = ONE;
        if (q < -ONE)
            q = -ONE;
        return q[31:0];
    endfunction

    function automatic real rand_angle();
        return ($urandom_range(0, 1000000) / 1000000.0) * 6.283185307 - 3.14159265;
    endfunction

    task automatic queue_pose(input logic [31:0] m00, m10, m20, m21, m22);
        pending_poses.push_back({$urandom(), $urandom(), $urandom(),
                                 m22, m21, m20, m10, m00});
    endtask

    task automatic queue_rotation(input real r, input real p, input real y);
        queue_pose(to_fx($cos(y) * $cos(p)), to_fx($sin(y) * $cos(p)),
                   to_fx(-$sin(p)), to_fx($cos(p) * $sin(r)),
                   to_fx($cos(p) * $cos(r)));
    endtask

    // advance the source: push the prediction of each accepted word, then load or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_gap      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_poses.push_back(pose_quaternion(s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_poses.size() > 0)
                begin
                    s_axis_tdata <= pending_poses.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if (pending_poses.size() > TAIL && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 4);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // check each result word against the oldest prediction, and hold m_axis_tready low at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_stall    <= 0;
            cycles        <= 0;
        end
        else
        begin
            cycles <= cycles + 1;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_poses.size() == 0)
                begin
                    $display("%t: unexpected word %h", $time, m_axis_tdata);
                    errors++;
                end
                else if (expected_poses[0] !== m_axis_tdata)
                begin
                    $display("%t: expected %h actual %h", $time,
                             expected_poses[0], m_axis_tdata);
                    errors++;
                    void'(expected_poses.pop_front());
                end
                else
                    void'(expected_poses.pop_front());
            end
            if (sink_stall > 0)
            begin
                sink_stall <= sink_stall - 1;
                m_axis_tready <= 1'b0;
            end
            else if (pending_poses.size() > TAIL && $urandom_range(0, 5) == 0)
            begin
                sink_stall <= $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        errors = 0;
        rst_n = 1'b0;
        queue_pose(32'sd1073741824, 0, 0, 0, 32'sd1073741824);
        queue_pose(0, 0, 0, 0, 0);
        queue_pose(-32'sd1073741824, 0, 0, 0, -32'sd1073741824);
        queue_pose(-32'sd1073741824, -32'sd1, 0, -32'sd1, -32'sd1073741824);
        queue_pose(0, 0, 32'sd1073741824, 0, 32'sd1073741824);
        queue_pose(0, 0, -32'sd1073741824, 0, 32'sd1073741824);
        queue_pose(32'sd1073741824, 32'sd1073741824, 32'sd1073741824,
                   32'sd1073741824, 32'sd1073741824);
        queue_pose(-32'sd1073741824, -32'sd1073741824, -32'sd1073741824,
                   -32'sd1073741824, -32'sd1073741824);
        queue_pose(32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1);
        queue_pose(-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1);
        queue_pose(0, 32'sd1073741824, 0, 32'sd1073741824, 0);
        queue_pose(0, -32'sd1073741824, 0, -32'sd1073741824, 0);
        queue_pose(32'sd5, 32'sd3, 32'sd1073741823, -32'sd7, 32'sd2);
        queue_rotation(0.3, 1.5707963, -0.7);
        queue_rotation(-2.9, -1.2, 3.1);
        queue_rotation(3.14159, 0.0, -3.14159);
        pending_poses.push_back({32'h7fffffff, 32'h80000000, 32'hffffffff, 160'd0});
        pending_poses.push_back({32'h80000000, 32'h7fffffff, 32'h00000000, 160'd0});
        for (int n = 0; n < 540; n++)
        begin
            if ($urandom_range(0, 9) < 6)
                queue_rotation(rand_angle(), rand_angle() / 2.0, rand_angle());
            else
                queue_pose(rand_entry(), rand_entry(), rand_entry(),
                           rand_entry(), rand_entry());
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        while ((pending_poses.size() > 0 || s_axis_tvalid || expected_poses.size() > 0)
               && cycles < LIMIT)
            @(posedge clk);
        if (cycles >= LIMIT)
        begin
            $display("rotation_matrix_to_quaternion_unit test failed");
            $finish;
        end
        else
        begin
            repeat (120) @(posedge clk);
            if (errors == 0 && expected_poses.size() == 0)
                $display("rotation_matrix_to_quaternion_unit test passed");
            else
                $display("rotation_matrix_to_quaternion_unit test failed");
            $finish;
        end
    end

endmodule

// ----- files.f -----
rtl/rmq_pkg.sv
rtl/rmq_sqrt_cell.sv
rtl/rmq_vec_cell.sv
rtl/rmq_rot_cell.sv
rtl/rmq_quat.sv
rtl/rotation_matrix_to_quaternion_unit.sv
bench/rotation_matrix_to_quaternion_unit_tb.sv
